[hw/rtl/afr_pkg.sv]
`timescale 1ns / 1ps
package afr_pkg;

  localparam int unsigned FRAME_BUFFER_BYTES = 64;
  localparam int unsigned ADDR_W = $clog2(FRAME_BUFFER_BYTES);
  localparam int unsigned CNT_W  = $clog2(FRAME_BUFFER_BYTES + 1);
  localparam int unsigned LEN_W  = 10;

  localparam logic [7:0] MATCH_ADDR_RST = 8'hF4;

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_BREAK = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic take;
    logic rd_en;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_good;
    logic slot_free;
    logic rd_last;
  } dp_status_t;

endpackage

[hw/rtl/afr_ram.sv]
`timescale 1ns / 1ps
module afr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/afr_ctrl.sv]
`timescale 1ns / 1ps
module afr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  afr_pkg::dp_status_t sts_i,
  output afr_pkg::ctrl_cmd_t  cmd_o
);

  afr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      afr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && sts_i.frame_good) begin
          state_d = afr_pkg::ST_READ;
        end
      end
      afr_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = afr_pkg::ST_LOAD;
      end
      afr_pkg::ST_LOAD: begin
        if (sts_i.slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.rd_last ? afr_pkg::ST_IDLE : afr_pkg::ST_READ;
        end
      end
      default: begin
        state_d = afr_pkg::ST_IDLE;
      end
    endcase
  end

  a_good_starts_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take && sts_i.frame_good |=> state_q == afr_pkg::ST_READ)
    else $error("good frame did not start a release");

endmodule

[hw/rtl/afr_datapath.sv]
`timescale 1ns / 1ps
module afr_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  afr_pkg::in_item_t   in_item_i,
  input  afr_pkg::ctrl_cmd_t  cmd_i,
  output afr_pkg::dp_status_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output afr_pkg::out_item_t  out_item_o
);

  logic [7:0]                 addr_q;
  logic                       armed_q, armed_d;
  logic [afr_pkg::CNT_W-1:0]  fill_q, fill_d;
  logic [afr_pkg::CNT_W-1:0]  len_q, len_d;
  logic [7:0]                 xor_q, xor_d;
  logic [afr_pkg::ADDR_W-1:0] rel_last_q, rel_last_d;
  logic [afr_pkg::ADDR_W-1:0] k_q, k_d;
  logic                       out_valid_q, out_valid_d;
  afr_pkg::out_item_t         out_item_q, out_item_d;

  logic                       is_byte;
  logic                       addr_ok;
  logic                       room;
  logic [afr_pkg::CNT_W-1:0]  fill_inc;
  logic [7:0]                 xor_new;
  logic [afr_pkg::LEN_W-1:0]  len_ext;
  logic                       len_bad;
  logic                       at_len;
  logic                       store;
  logic [7:0]                 rdata;

  assign is_byte  = in_item_i.req_type == afr_pkg::REQ_BYTE;
  assign addr_ok  = (fill_q != '0) || (in_item_i.rx_byte == addr_q);
  assign room     = fill_q < afr_pkg::CNT_W'(afr_pkg::FRAME_BUFFER_BYTES);
  assign fill_inc = fill_q + afr_pkg::CNT_W'(1);
  assign xor_new  = xor_q ^ in_item_i.rx_byte;
  assign len_ext  = afr_pkg::LEN_W'(in_item_i.rx_byte) + afr_pkg::LEN_W'(2);
  assign len_bad  = (in_item_i.rx_byte == 8'd0)
                 || (len_ext > afr_pkg::LEN_W'(afr_pkg::FRAME_BUFFER_BYTES));
  assign at_len   = (fill_inc > afr_pkg::CNT_W'(2)) && (fill_inc == len_q);
  assign store    = cmd_i.take && is_byte && armed_q && addr_ok && room;

  assign sts_o.frame_good = is_byte && armed_q && addr_ok && room && at_len
                         && (xor_new == 8'd0);
  assign sts_o.slot_free  = !out_valid_q || out_ready_i;
  assign sts_o.rd_last    = k_q == rel_last_q;

  always_comb begin
    armed_d    = armed_q;
    fill_d     = fill_q;
    len_d      = len_q;
    xor_d      = xor_q;
    rel_last_d = rel_last_q;
    if (cmd_i.take) begin
      if (!is_byte) begin
        armed_d = 1'b1;
        fill_d  = '0;
        len_d   = '0;
        xor_d   = '0;
      end else if (armed_q) begin
        if (!addr_ok || !room) begin
          armed_d = 1'b0;
          fill_d  = '0;
          len_d   = '0;
          xor_d   = '0;
        end else if (fill_inc == afr_pkg::CNT_W'(2)) begin
          if (len_bad) begin
            armed_d = 1'b0;
            fill_d  = '0;
            len_d   = '0;
            xor_d   = '0;
          end else begin
            len_d  = len_ext[afr_pkg::CNT_W-1:0];
            fill_d = fill_inc;
            xor_d  = xor_new;
          end
        end else if (at_len) begin
          fill_d = '0;
          len_d  = '0;
          xor_d  = '0;
          if (xor_new != 8'd0) begin
            armed_d = 1'b0;
          end else begin
            rel_last_d = fill_q[afr_pkg::ADDR_W-1:0];
          end
        end else begin
          fill_d = fill_inc;
          xor_d  = xor_new;
        end
      end
    end
  end

  always_comb begin
    k_d = k_q;
    if (cmd_i.take) begin
      k_d = '0;
    end else if (cmd_i.load) begin
      k_d = k_q + afr_pkg::ADDR_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (cmd_i.load) begin
      out_valid_d           = 1'b1;
      out_item_d.frame_byte = rdata;
      out_item_d.last_byte  = k_q == rel_last_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= afr_pkg::MATCH_ADDR_RST;
      armed_q     <= 1'b0;
      fill_q      <= '0;
      len_q       <= '0;
      xor_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        addr_q <= cfg_wdata_i;
      end
      armed_q     <= armed_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      xor_q       <= xor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rel_last_q <= rel_last_d;
    k_q        <= k_d;
    out_item_q <= out_item_d;
  end

  afr_ram #(
    .WIDTH (8),
    .DEPTH (afr_pkg::FRAME_BUFFER_BYTES)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (fill_q[afr_pkg::ADDR_W-1:0]),
    .wdata_i (in_item_i.rx_byte),
    .re_i    (cmd_i.rd_en),
    .raddr_i (k_q),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while held");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < afr_pkg::CNT_W'(afr_pkg::FRAME_BUFFER_BYTES))
    else $error("fill count beyond frame store");

  a_read_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (k_q <= rel_last_q))
    else $error("release read past end of frame");

endmodule

[hw/rtl/addressed_frame_receiver.sv]
`timescale 1ns / 1ps
// Release: once the final byte of a good frame is taken, each byte is read from the store
// (ST_READ) and then loaded into the output register (ST_LOAD) when that register is free.
// Throughput: one item per cycle while receiving; no new item is taken during a release.
// A frame of L + 2 bytes thus blocks the input until its last byte is in the output register.
// Reset: disarmed, counts and checksum cleared, address 0xF4; the frame store is not cleared.
module addressed_frame_receiver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  afr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output afr_pkg::out_item_t out_item_o
);

  afr_pkg::ctrl_cmd_t  cmd;
  afr_pkg::dp_status_t sts;

  afr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  afr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[tb/addressed_frame_receiver_tb.sv]
`timescale 1ns / 1ps
module addressed_frame_receiver_tb;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct {
    afr_pkg::in_item_t item;
    bit                hold;
  } line_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [7:0]         cfg_wdata = 8'h00;
  logic               in_valid = 1'b0;
  logic               in_ready;
  afr_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  afr_pkg::out_item_t out_item;

  line_item_t          line_q[$];
  afr_pkg::out_item_t  frame_bytes_due[$];
  logic        in_taken = 1'b0;
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 60;
  int unsigned errors = 0;
  int unsigned items_taken = 0;
  int unsigned frames_released = 0;
  int unsigned bytes_checked = 0;
  int unsigned stall_cycles = 0;

  logic [7:0] rx_match_addr;
  logic       rx_armed;
  logic [6:0] rx_fill;
  logic [6:0] rx_len;
  logic [7:0] rx_xor;
  logic [7:0] rx_store [afr_pkg::FRAME_BUFFER_BYTES];

  addressed_frame_receiver uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic drop_frame();
    rx_armed = 1'b0;
    rx_fill  = '0;
    rx_len   = '0;
    rx_xor   = '0;
  endtask

  task automatic receive_line_item(input afr_pkg::in_item_t it);
    afr_pkg::out_item_t released;
    if (it.req_type == afr_pkg::REQ_BREAK) begin
      rx_armed = 1'b1;
      rx_fill  = '0;
      rx_len   = '0;
      rx_xor   = '0;
    end else if (rx_armed) begin
      if (rx_fill == 0 && it.rx_byte != rx_match_addr) begin
        drop_frame();
      end else if (rx_fill >= 7'(afr_pkg::FRAME_BUFFER_BYTES)) begin
        drop_frame();
      end else begin
        rx_store[rx_fill[afr_pkg::ADDR_W-1:0]] = it.rx_byte;
        rx_fill = rx_fill + 7'd1;
        rx_xor  = rx_xor ^ it.rx_byte;
        if (rx_fill == 7'd2) begin
          if (it.rx_byte == 8'h00 ||
              int'(it.rx_byte) + 2 > int'(afr_pkg::FRAME_BUFFER_BYTES)) begin
            drop_frame();
          end else begin
            rx_len = 7'(int'(it.rx_byte) + 2);
          end
        end else if (rx_fill > 7'd2 && rx_fill == rx_len) begin
          if (rx_xor != 8'h00) begin
            drop_frame();
          end else begin
            for (int k = 0; k < int'(rx_len); k++) begin
              released.frame_byte = rx_store[afr_pkg::ADDR_W'(k)];
              released.last_byte  = (k + 1 == int'(rx_len));
              frame_bytes_due.push_back(released);
            end
            frames_released++;
            rx_fill = '0;
            rx_len  = '0;
            rx_xor  = '0;
          end
        end
      end
    end
  endtask

  // compare released bytes, then advance the receiver copy on accepted items
  always @(posedge clk) begin
    afr_pkg::out_item_t want;
    in_taken <= in_valid && in_ready;
    if (!rst_n) begin
      rx_match_addr = afr_pkg::MATCH_ADDR_RST;
      drop_frame();
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (cfg_we) begin
        rx_match_addr = cfg_wdata;
        stall_cycles = 0;
      end
      if (out_valid && out_ready) begin
        stall_cycles = 0;
        bytes_checked++;
        if (frame_bytes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte %02h last %0b", $time,
                   out_item.frame_byte, out_item.last_byte);
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_item.frame_byte !== want.frame_byte) begin
            errors++;
            $display("%0t: frame_byte expected %02h actual %02h", $time,
                     want.frame_byte, out_item.frame_byte);
          end
          if (out_item.last_byte !== want.last_byte) begin
            errors++;
            $display("%0t: last_byte expected %0b actual %0b", $time,
                     want.last_byte, out_item.last_byte);
          end
        end
      end
      if (in_valid && in_ready) begin
        stall_cycles = 0;
        items_taken++;
        receive_line_item(in_item);
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, stall_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // hold an item until taken; a held item waits for every due byte first
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
    end else if (line_q.size() != 0 && !(line_q[0].hold && frame_bytes_due.size() != 0) &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_item  <= line_q[0].item;
      in_valid <= 1'b1;
      line_q.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic push_line(input logic kind, input logic [7:0] value, input bit hold);
    line_item_t li;
    li.item.req_type = kind;
    li.item.rx_byte  = value;
    li.hold          = hold;
    line_q.push_back(li);
  endtask

  task automatic add_frame(input logic [7:0] addr, input int len, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    sum = addr ^ 8'(len);
    push_line(afr_pkg::REQ_BYTE, addr, 1'b0);
    push_line(afr_pkg::REQ_BYTE, 8'(len), 1'b0);
    for (int k = 0; k < len - 1; k++) begin
      b = 8'($urandom_range(255));
      sum ^= b;
      push_line(afr_pkg::REQ_BYTE, b, 1'b0);
    end
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    push_line(afr_pkg::REQ_BYTE, sum, 1'b0);
  endtask

  task automatic add_random_traffic(input logic [7:0] addr, input int count);
    int unsigned pick;
    int target;
    target = line_q.size() + count;
    push_line(afr_pkg::REQ_BREAK, 8'($urandom_range(255)), 1'b0);
    while (line_q.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        if ($urandom_range(15) == 0) add_frame(addr, $urandom_range(9, 62), 1'b0);
        else add_frame(addr, $urandom_range(1, 8), 1'b0);
      end else if (pick < 68) begin
        add_frame(addr, $urandom_range(1, 8), 1'b1);
        push_line(afr_pkg::REQ_BREAK, 8'($urandom_range(255)), 1'b0);
      end else if (pick < 74) begin
        push_line(afr_pkg::REQ_BYTE, addr ^ 8'($urandom_range(1, 255)), 1'b0);
        push_line(afr_pkg::REQ_BYTE, 8'($urandom_range(255)), 1'b0);
        push_line(afr_pkg::REQ_BREAK, 8'($urandom_range(255)), 1'b0);
      end else if (pick < 78) begin
        push_line(afr_pkg::REQ_BYTE, addr, 1'b0);
        push_line(afr_pkg::REQ_BYTE, 8'h00, 1'b0);
        push_line(afr_pkg::REQ_BREAK, 8'($urandom_range(255)), 1'b0);
      end else if (pick < 82) begin
        push_line(afr_pkg::REQ_BYTE, addr, 1'b0);
        push_line(afr_pkg::REQ_BYTE, 8'($urandom_range(63, 255)), 1'b0);
        push_line(afr_pkg::REQ_BREAK, 8'($urandom_range(255)), 1'b0);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4))
          push_line(afr_pkg::REQ_BYTE, 8'($urandom_range(255)), 1'b0);
        push_line(afr_pkg::REQ_BREAK, 8'($urandom_range(255)), 1'b0);
      end else begin
        push_line(afr_pkg::REQ_BREAK, 8'($urandom_range(255)), $urandom_range(3) == 0);
      end
    end
  endtask

  task automatic wait_idle();
    while (line_q.size() != 0 || in_valid || frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_match_address(input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [7:0] last_addr;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    push_line(afr_pkg::REQ_BYTE, 8'hFF, 1'b0);
    push_line(afr_pkg::REQ_BREAK, 8'hFF, 1'b0);
    add_frame(afr_pkg::MATCH_ADDR_RST, 1, 1'b0);
    add_frame(afr_pkg::MATCH_ADDR_RST, 2, 1'b0);
    push_line(afr_pkg::REQ_BYTE, afr_pkg::MATCH_ADDR_RST ^ 8'h01, 1'b0);
    push_line(afr_pkg::REQ_BYTE, afr_pkg::MATCH_ADDR_RST, 1'b0);
    push_line(afr_pkg::REQ_BREAK, 8'h00, 1'b1);
    push_line(afr_pkg::REQ_BYTE, afr_pkg::MATCH_ADDR_RST, 1'b0);
    push_line(afr_pkg::REQ_BYTE, 8'h00, 1'b0);
    push_line(afr_pkg::REQ_BREAK, 8'h5A, 1'b0);
    push_line(afr_pkg::REQ_BYTE, afr_pkg::MATCH_ADDR_RST, 1'b0);
    push_line(afr_pkg::REQ_BYTE, 8'd63, 1'b0);
    push_line(afr_pkg::REQ_BREAK, 8'hA5, 1'b0);
    add_frame(afr_pkg::MATCH_ADDR_RST, 3, 1'b1);
    push_line(afr_pkg::REQ_BREAK, 8'h00, 1'b0);
    add_frame(afr_pkg::MATCH_ADDR_RST, 1, 1'b0);
    wait_idle();

    write_match_address(8'h00);
    push_line(afr_pkg::REQ_BREAK, 8'h00, 1'b0);
    add_frame(8'h00, 62, 1'b0);
    add_random_traffic(8'h00, 35);
    wait_idle();

    send_idle_pct = 60;
    recv_idle_pct = 32;
    write_match_address(8'hFF);
    add_random_traffic(8'hFF, 35);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    last_addr = 8'($urandom_range(255));
    write_match_address(last_addr);
    add_random_traffic(last_addr, 35);
    wait_idle();

    $display("Took %0d line items over addresses F4, 00, FF and %02h", items_taken, last_addr);
    $display("Released %0d frames, %0d bytes checked, %0d mismatches",
             frames_released, bytes_checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
